// ===== hw/rtl/scqe_pkg.sv =====
package scqe_pkg;

    localparam int WORD_W = 16;
    localparam int FILL_W = 8;
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;

    localparam logic [1:0] OP_ENQ   = 2'd0;
    localparam logic [1:0] OP_TICK  = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [WORD_W-1:0] CMD_STOP      = 16'd0;
    localparam logic [WORD_W-1:0] CMD_DIR_POS   = 16'd1;
    localparam logic [WORD_W-1:0] CMD_DIR_NEG   = 16'd2;
    localparam logic [WORD_W-1:0] CMD_UNTIL_MIN = 16'd3;
    localparam logic [WORD_W-1:0] CMD_WHILE_MIN = 16'd4;
    localparam logic [WORD_W-1:0] CMD_STEP_ON   = 16'd5;
    localparam logic [WORD_W-1:0] CMD_STEP_OFF  = 16'd6;
    localparam logic [WORD_W-1:0] CMD_LIMIT     = 16'd7;

    localparam logic [PADDR_W-1:0] ADDR_START_INTERVAL = 3'd0;
    localparam logic [WORD_W-1:0] START_INTERVAL_RST = 16'd16000;

    typedef struct packed {
        logic              is_enq;
        logic              is_tick;
        logic              is_start;
        logic [WORD_W-1:0] word;
        logic              min_switch;
    } cmd_item_t;

    typedef struct packed {
        logic              accepted;
        logic              started;
        logic              running;
        logic              direction;
        logic              step_enabled;
        logic [WORD_W-1:0] interval;
        logic              holding;
        logic [FILL_W-1:0] fill_level;
    } result_t;

endpackage

// ===== hw/rtl/scqe_ram.sv =====
module scqe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/scqe_front.sv =====
module scqe_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          operation,
    input  logic [15:0]         word,
    input  logic                min_switch,
    output logic                q_valid,
    output scqe_pkg::cmd_item_t q_item,
    input  logic                q_pop
);
    import scqe_pkg::*;

    cmd_item_t  ent_reg [2];
    logic       wptr_reg;
    logic       wptr_next;
    logic       rptr_reg;
    logic       rptr_next;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    cmd_item_t  dec_item;

    always_comb
    begin
        dec_item.is_enq     = 1'b0;
        dec_item.is_tick    = 1'b0;
        dec_item.is_start   = 1'b0;
        dec_item.word       = word;
        dec_item.min_switch = min_switch;
        unique case (operation)
            OP_ENQ:   dec_item.is_enq   = 1'b1;
            OP_TICK:  dec_item.is_tick  = 1'b1;
            OP_START: dec_item.is_start = 1'b1;
            default:  ;
        endcase
    end

    assign in_stall = cnt_reg[1];
    assign push     = in_valid & ~in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rptr_reg];

    always_comb
    begin
        wptr_next = push  ? ~wptr_reg : wptr_reg;
        rptr_next = q_pop ? ~rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wptr_reg] <= dec_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

endmodule

// ===== hw/rtl/scqe_back.sv =====
module scqe_back #(
    parameter int RING_DEPTH = 256
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_valid,
    input  scqe_pkg::cmd_item_t q_item,
    output logic                q_pop,
    input  logic [15:0]         start_interval,
    output logic                out_valid,
    input  logic                out_stall,
    output scqe_pkg::result_t   res
);
    import scqe_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(RING_DEPTH);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] x);
        return (x == LAST_IDX) ? '0 : x + 1'b1;
    endfunction

    logic [1:0]        st_reg, st_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [AW-1:0]     tail_reg, tail_next;
    logic              run_reg, run_next;
    logic              dir_reg, dir_next;
    logic              step_reg, step_next;
    logic [WORD_W-1:0] ival_reg, ival_next;
    logic              min_reg, min_next;
    logic              out_valid_reg, out_valid_next;
    result_t           res_reg;

    logic              fin;
    logic              fin_acc;
    logic              fin_start;
    logic              fin_hold;
    logic              ram_we;
    logic [WORD_W-1:0] ram_rdata;
    logic [AW-1:0]     tail_p1, tail_p2, tail_p3;
    logic              ring_full;
    logic [AW:0]       fill_w;
    logic [AW+8:0]     fill_ext;
    logic [WORD_W-1:0] w;

    scqe_ram #(
        .WIDTH (WORD_W),
        .DEPTH (RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (q_item.word),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign tail_p1   = wrap_inc(tail_reg);
    assign tail_p2   = wrap_inc(tail_p1);
    assign tail_p3   = wrap_inc(tail_p2);
    assign ring_full = (head_reg == tail_p2);
    assign w         = ram_rdata;
    assign q_pop     = (st_reg == ST_IDLE) & q_valid & ~out_valid_reg;

    always_comb
    begin
        st_next   = st_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        run_next  = run_reg;
        dir_next  = dir_reg;
        step_next = step_reg;
        ival_next = ival_reg;
        min_next  = min_reg;
        fin       = 1'b0;
        fin_acc   = 1'b0;
        fin_start = 1'b0;
        fin_hold  = 1'b0;
        ram_we    = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_pop)
                begin
                    fin = 1'b1;
                    if (q_item.is_enq)
                    begin
                        if (!ring_full)
                        begin
                            ram_we    = 1'b1;
                            tail_next = tail_p1;
                            fin_acc   = 1'b1;
                        end
                        if (!run_reg && (ring_full || head_reg == tail_p3))
                        begin
                            run_next  = 1'b1;
                            ival_next = start_interval;
                            fin_start = 1'b1;
                        end
                    end
                    else if (q_item.is_tick)
                    begin
                        if (run_reg)
                        begin
                            fin      = 1'b0;
                            min_next = q_item.min_switch;
                            st_next  = ST_READ;
                        end
                    end
                    else if (q_item.is_start)
                    begin
                        if (!run_reg)
                        begin
                            run_next  = 1'b1;
                            ival_next = start_interval;
                            fin_start = 1'b1;
                        end
                    end
                end
            end
            ST_READ:
            begin
                if (head_reg == tail_reg)
                begin
                    run_next = 1'b0;
                    fin      = 1'b1;
                    st_next  = ST_IDLE;
                end
                else
                begin
                    st_next = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (w >= CMD_LIMIT)
                begin
                    head_next = wrap_inc(head_reg);
                    ival_next = w;
                    fin       = 1'b1;
                    st_next   = ST_IDLE;
                end
                else if ((w == CMD_UNTIL_MIN && !min_reg) || (w == CMD_WHILE_MIN && min_reg))
                begin
                    fin_hold = 1'b1;
                    fin      = 1'b1;
                    st_next  = ST_IDLE;
                end
                else
                begin
                    head_next = wrap_inc(head_reg);
                    st_next   = ST_READ;
                    unique case (w)
                        CMD_STOP:
                        begin
                            run_next = 1'b0;
                            fin      = 1'b1;
                            st_next  = ST_IDLE;
                        end
                        CMD_DIR_POS:  dir_next  = 1'b1;
                        CMD_DIR_NEG:  dir_next  = 1'b0;
                        CMD_STEP_ON:  step_next = 1'b1;
                        CMD_STEP_OFF: step_next = 1'b0;
                        default:      ;
                    endcase
                end
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fill_w = {1'b0, tail_next} - {1'b0, head_next}
               + ((tail_next < head_next) ? DEPTH_W : '0);
        fill_ext = {8'b0, fill_w};
        out_valid_next = fin | (out_valid_reg & out_stall);
    end

    always_ff @(posedge clk)
    begin
        if (fin)
        begin
            res_reg.accepted     <= fin_acc;
            res_reg.started      <= fin_start;
            res_reg.running      <= run_next;
            res_reg.direction    <= dir_next;
            res_reg.step_enabled <= step_next;
            res_reg.interval     <= ival_next;
            res_reg.holding      <= fin_hold;
            res_reg.fill_level   <= fill_ext[FILL_W-1:0];
        end
        min_reg <= min_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= ST_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            run_reg       <= 1'b0;
            dir_reg       <= 1'b0;
            step_reg      <= 1'b0;
            ival_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            run_reg       <= run_next;
            dir_reg       <= dir_next;
            step_reg      <= step_next;
            ival_reg      <= ival_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign res       = res_reg;

    a_busy_out_free: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != ST_IDLE) |-> !out_valid_reg)
        else $error("sequencer busy while result pending");

    a_hold_running: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && res_reg.holding) |-> res_reg.running)
        else $error("holding result with engine halted");

    a_fill_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fill_w <= DEPTH_W - 2'd2)
        else $error("ring fill beyond capacity");

    a_tick_running: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == ST_READ) |-> run_reg)
        else $error("tick sequence with engine halted");

endmodule

// ===== hw/rtl/stepper_command_queue_engine.sv =====
// Stepper-axis command engine.
// Input channel (in_valid/in_stall): operation 0 enqueues word into the
// command ring, 1 is a timer-expiry tick, 2 requests a start. Every input
// transfer yields exactly one result transfer on out_valid/out_stall with
// accepted, started, running, direction, step_enabled, interval, holding and
// fill_level as they stand after the item.
// APB register 0 (byte address 0) holds start_interval, loaded on start.
// An enqueue, start or idle tick passes through a queue entry and then the
// sequencer's result register; a running tick also steps through ST_READ
// and ST_EVAL for each ring word it reads, and ST_READ once more when it
// finds the ring empty, as each word goes through the ring RAM's registered
// read port. The sequencer takes the next item only once its result is gone.
// A two-entry queue sits in front of the sequencer, so up to two items are
// taken while a result waits. When out_stall is high the result holds and
// the sequencer waits; in_stall rises once the queue is full.
// Reset empties the ring, halts the engine, clears direction, step enable
// and interval, and sets start_interval to 16000. Ring contents are not
// cleared; only words between head and tail are ever read.
module stepper_command_queue_engine #(
    parameter int RING_DEPTH = 256
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] word,
    input  logic        min_switch,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        accepted,
    output logic        started,
    output logic        running,
    output logic        direction,
    output logic        step_enabled,
    output logic [15:0] interval,
    output logic        holding,
    output logic [7:0]  fill_level
);
    import scqe_pkg::*;

    logic [WORD_W-1:0] start_ival_reg;
    logic [WORD_W-1:0] start_ival_next;
    logic              cfg_wr;
    logic              q_valid;
    logic              q_pop;
    cmd_item_t         q_item;
    result_t           res;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & (paddr == ADDR_START_INTERVAL);
    assign start_ival_next = cfg_wr ? pwdata[WORD_W-1:0] : start_ival_reg;
    assign prdata = (paddr == ADDR_START_INTERVAL) ? {16'b0, start_ival_reg} : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_ival_reg <= START_INTERVAL_RST;
        end
        else
        begin
            start_ival_reg <= start_ival_next;
        end
    end

    scqe_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .operation  (operation),
        .word       (word),
        .min_switch (min_switch),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop)
    );

    scqe_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_item         (q_item),
        .q_pop          (q_pop),
        .start_interval (start_ival_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .res            (res)
    );

    assign accepted     = res.accepted;
    assign started      = res.started;
    assign running      = res.running;
    assign direction    = res.direction;
    assign step_enabled = res.step_enabled;
    assign interval     = res.interval;
    assign holding      = res.holding;
    assign fill_level   = res.fill_level;

endmodule
